// ===== rtl/pcov_pkg.sv =====
// Package for the point covariance accumulator.
// Holds field widths, the point limit and the product operand tables.
// No dependencies.
package pcov_pkg;

	localparam int COORD_W = 20;
	localparam int SUM1_W = 32;
	localparam int SUM2_W = 52;
	localparam int PROD_W = 2 * COORD_W;
	localparam int COV_W = 41;
	localparam int CNT_W = 13;
	localparam int REM_W = CNT_W + 1;
	localparam int ITER_W = $clog2(SUM2_W);
	localparam int N_PROD = 6;
	localparam int N_DIV = 3 + N_PROD;

	localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(4096);
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(SUM2_W - 1);

	// Operand pairs of the six second-order products: xx, xy, xz, yy, yz, zz.
	function automatic logic [1:0] op_a(input logic [2:0] idx);
		logic [1:0] r;
		case (idx)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4: r = 2'd1;
			3'd5: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] op_b(input logic [2:0] idx);
		logic [1:0] r;
		case (idx)
			3'd0: r = 2'd0;
			3'd1, 3'd3: r = 2'd1;
			3'd2, 3'd4, 3'd5: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/point_covariance_accumulator.sv =====
// Centroid and 3x3 covariance of a point set, built around one shared
// multiplier and one bit-serial restoring divider under a small sequencer.
// Depends on pcov_pkg.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid, in_stall   | x_coord, y_coord, z_coord, last_point
//   output  | out       | out_valid, out_stall | centroid_x/y/z, cov_xx..cov_zz,
//           |           |                      | num_points, overflow
//
// A point that is not the last is accepted and then runs the six products, which share
// a single 20 by 20 multiplier.
// A point that arrives with the set full is dropped in its accept cycle.
// The last point adds 9 divisions (the divider retires one quotient bit per cycle
// over 52 bits) and the six centroid products.
// The result is held in its registers until it is taken; no point is accepted
// meanwhile. Reset clears all sums, the point count and the overflow flag.
module point_covariance_accumulator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [pcov_pkg::COORD_W-1:0] x_coord,
	input  logic signed [pcov_pkg::COORD_W-1:0] y_coord,
	input  logic signed [pcov_pkg::COORD_W-1:0] z_coord,
	input  logic last_point,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [pcov_pkg::COORD_W-1:0] centroid_x,
	output logic signed [pcov_pkg::COORD_W-1:0] centroid_y,
	output logic signed [pcov_pkg::COORD_W-1:0] centroid_z,
	output logic signed [pcov_pkg::COV_W-1:0] cov_xx,
	output logic signed [pcov_pkg::COV_W-1:0] cov_xy,
	output logic signed [pcov_pkg::COV_W-1:0] cov_xz,
	output logic signed [pcov_pkg::COV_W-1:0] cov_yy,
	output logic signed [pcov_pkg::COV_W-1:0] cov_yz,
	output logic signed [pcov_pkg::COV_W-1:0] cov_zz,
	output logic [pcov_pkg::CNT_W-1:0] num_points,
	output logic overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DLOAD,
		ST_DRUN,
		ST_DSTORE,
		ST_COV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic last_q;
	logic signed [pcov_pkg::COORD_W-1:0] pt_q [3];
	logic signed [pcov_pkg::SUM1_W-1:0] sum1_q [3];
	logic signed [pcov_pkg::SUM2_W-1:0] sum2_q [pcov_pkg::N_PROD];
	logic [pcov_pkg::CNT_W-1:0] cnt_q;
	logic drop_q;
	logic signed [pcov_pkg::PROD_W-1:0] prod_q;
	logic [pcov_pkg::SUM2_W-1:0] dvd_q;
	logic [pcov_pkg::REM_W-1:0] rem_q;
	logic neg_q;
	logic [pcov_pkg::ITER_W-1:0] iter_q;
	logic [3:0] sel_q;
	logic signed [pcov_pkg::COORD_W-1:0] mean_q [3];
	logic signed [pcov_pkg::COV_W-1:0] cov_q [pcov_pkg::N_PROD];

	logic [1:0] idx_a;
	logic [1:0] idx_b;
	logic signed [pcov_pkg::COORD_W-1:0] mul_a;
	logic signed [pcov_pkg::COORD_W-1:0] mul_b;
	logic signed [pcov_pkg::PROD_W-1:0] prod_d;
	logic [2:0] step_prev;
	logic [2:0] sel2;
	logic signed [pcov_pkg::SUM2_W-1:0] dsrc;
	logic [pcov_pkg::SUM2_W-1:0] dabs;
	logic [pcov_pkg::REM_W-1:0] rem_sh;
	logic rem_ge;
	logic [pcov_pkg::SUM2_W-1:0] quot;
	logic in_acc;
	logic out_acc;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	assign idx_a = pcov_pkg::op_a(step_q);
	assign idx_b = pcov_pkg::op_b(step_q);
	assign mul_a = (state_q == ST_COV) ? mean_q[idx_a] : pt_q[idx_a];
	assign mul_b = (state_q == ST_COV) ? mean_q[idx_b] : pt_q[idx_b];
	assign prod_d = mul_a * mul_b;
	assign step_prev = 3'(step_q - 3'd1);

	assign sel2 = 3'(sel_q - 4'd3);
	assign dsrc = (sel_q < 4'd3) ? pcov_pkg::SUM2_W'(sum1_q[sel_q[1:0]]) : sum2_q[sel2];
	assign dabs = dsrc[pcov_pkg::SUM2_W-1] ? pcov_pkg::SUM2_W'(-dsrc) : pcov_pkg::SUM2_W'(dsrc);
	assign rem_sh = {rem_q[pcov_pkg::REM_W-2:0], dvd_q[pcov_pkg::SUM2_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, cnt_q});
	assign quot = neg_q ? pcov_pkg::SUM2_W'(-dvd_q) : dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			last_q <= 1'b0;
			cnt_q <= '0;
			drop_q <= 1'b0;
			iter_q <= '0;
			sel_q <= '0;
			prod_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pt_q[i] <= '0;
				mean_q[i] <= '0;
				sum1_q[i] <= '0;
			end
			for (int i = 0; i < pcov_pkg::N_PROD; i++) begin
				sum2_q[i] <= '0;
				cov_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= last_point;
						sel_q <= '0;
						if (cnt_q == pcov_pkg::MAX_POINTS) begin
							drop_q <= 1'b1;
							state_q <= last_point ? ST_DLOAD : ST_IDLE;
						end else begin
							pt_q[0] <= x_coord;
							pt_q[1] <= y_coord;
							pt_q[2] <= z_coord;
							sum1_q[0] <= sum1_q[0] + pcov_pkg::SUM1_W'(x_coord);
							sum1_q[1] <= sum1_q[1] + pcov_pkg::SUM1_W'(y_coord);
							sum1_q[2] <= sum1_q[2] + pcov_pkg::SUM1_W'(z_coord);
							cnt_q <= cnt_q + 1'b1;
							step_q <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= prod_d;
					if (step_q != 3'd0) begin
						sum2_q[step_prev] <= sum2_q[step_prev] + pcov_pkg::SUM2_W'(prod_q);
					end
					if (step_q == 3'(pcov_pkg::N_PROD)) begin
						state_q <= last_q ? ST_DLOAD : ST_IDLE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DLOAD: begin
					dvd_q <= dabs;
					neg_q <= dsrc[pcov_pkg::SUM2_W-1];
					rem_q <= '0;
					iter_q <= '0;
					state_q <= ST_DRUN;
				end
				ST_DRUN: begin
					rem_q <= rem_ge ? pcov_pkg::REM_W'(rem_sh - {1'b0, cnt_q}) : rem_sh;
					dvd_q <= {dvd_q[pcov_pkg::SUM2_W-2:0], rem_ge};
					iter_q <= iter_q + 1'b1;
					if (iter_q == pcov_pkg::LAST_ITER) begin
						state_q <= ST_DSTORE;
					end
				end
				ST_DSTORE: begin
					if (sel_q < 4'd3) begin
						mean_q[sel_q[1:0]] <= quot[pcov_pkg::COORD_W-1:0];
					end else begin
						cov_q[sel2] <= quot[pcov_pkg::COV_W-1:0];
					end
					if (sel_q == 4'(pcov_pkg::N_DIV - 1)) begin
						step_q <= '0;
						state_q <= ST_COV;
					end else begin
						sel_q <= sel_q + 4'd1;
						state_q <= ST_DLOAD;
					end
				end
				ST_COV: begin
					prod_q <= prod_d;
					if (step_q != 3'd0) begin
						cov_q[step_prev] <= cov_q[step_prev] - pcov_pkg::COV_W'(prod_q);
					end
					if (step_q == 3'(pcov_pkg::N_PROD)) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						cnt_q <= '0;
						drop_q <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							sum1_q[i] <= '0;
						end
						for (int i = 0; i < pcov_pkg::N_PROD; i++) begin
							sum2_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign centroid_x = mean_q[0];
	assign centroid_y = mean_q[1];
	assign centroid_z = mean_q[2];
	assign cov_xx = cov_q[0];
	assign cov_xy = cov_q[1];
	assign cov_xz = cov_q[2];
	assign cov_yy = cov_q[3];
	assign cov_yz = cov_q[4];
	assign cov_zz = cov_q[5];
	assign num_points = cnt_q;
	assign overflow = drop_q;

	// A result always carries at least one point.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (num_points != '0))
		else $error("result with empty point set");

	// Points are only dropped once the set is full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (cnt_q == pcov_pkg::MAX_POINTS))
		else $error("overflow flagged before the set was full");

	// The point count never passes the limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pcov_pkg::MAX_POINTS)
		else $error("point count beyond limit");

	// Taking a result clears the set.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |=> (cnt_q == '0) && !drop_q && !out_valid)
		else $error("set not cleared after result");

endmodule
